// File: rtl/core/ffpa_pkg.sv
// Shared types, sizes and datapath command codes of the first-fit pool allocator.
// Used by the modules under rtl/core other than ffpa_ram; depends on nothing.
package ffpa_pkg;

   localparam int MAX_SEGMENTS   = 64;
   localparam int POOL_ADDR_BITS = 16;
   localparam int LEN_W          = POOL_ADDR_BITS + 1;
   localparam int IDX_W          = $clog2(MAX_SEGMENTS);
   localparam int CNT_W          = $clog2(MAX_SEGMENTS + 1);
   localparam int OUT_CNT_W      = 7;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << POOL_ADDR_BITS;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Request modes
   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_CHECK  = 2'd2;
   localparam logic [1:0] MODE_REINIT = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_SIZE = '0;

   // Datapath commands
   localparam logic [3:0] CMD_NONE    = 4'd0;
   localparam logic [3:0] CMD_LOAD    = 4'd1;
   localparam logic [3:0] CMD_INIT    = 4'd2;
   localparam logic [3:0] CMD_FAIL    = 4'd3;
   localparam logic [3:0] CMD_SCAN_RD = 4'd4;
   localparam logic [3:0] CMD_SCAN_EV = 4'd5;
   localparam logic [3:0] CMD_TAKE    = 4'd6;
   localparam logic [3:0] CMD_FULL    = 4'd7;
   localparam logic [3:0] CMD_UP_INIT = 4'd8;
   localparam logic [3:0] CMD_UP_RD   = 4'd9;
   localparam logic [3:0] CMD_UP_WR   = 4'd10;
   localparam logic [3:0] CMD_TAIL    = 4'd11;
   localparam logic [3:0] CMD_HEAD    = 4'd12;
   localparam logic [3:0] CMD_NEXT_RD = 4'd13;
   localparam logic [3:0] CMD_NEXT_EV = 4'd14;
   localparam logic [3:0] CMD_MERGE   = 4'd15;
   // shift-down steps reuse the shift-up read/write pair; the read alias is below
   localparam logic [3:0] CMD_DN_RD   = CMD_UP_RD;

   typedef logic [3:0] cmd_type;

   typedef struct packed {
      logic [POOL_ADDR_BITS-1:0] start;
      logic [LEN_W-1:0]          len;
      logic                      free;
   } seg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       zero_size;
      logic       match;
      logic       last;
      logic       exact;
      logic       full;
      logic       has_next;
      logic       up_done;
      logic       dn_done;
      logic       shift_down;
   } dp_status_type;

endpackage

// File: rtl/core/ffpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the segment table of the allocator.
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ffpa_datapath.sv
// Datapath of the allocator: segment table RAM, scan cursor, entry holding
// registers, segment counts and result registers. Depends on ffpa_pkg, ffpa_ram.
module ffpa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ffpa_pkg::cmd_type                  cmd,
   input  logic                               dn_phase,
   input  logic [1:0]                         req_mode,
   input  logic [ffpa_pkg::LEN_W-1:0]         req_request_size,
   input  logic [ffpa_pkg::POOL_ADDR_BITS-1:0] req_address,
   input  logic [ffpa_pkg::LEN_W-1:0]         pool_size,
   output ffpa_pkg::dp_status_type            status,
   output logic [1:0]                         rsp_status,
   output logic [ffpa_pkg::POOL_ADDR_BITS-1:0] rsp_block_address,
   output logic [ffpa_pkg::OUT_CNT_W-1:0]     rsp_allocated_count,
   output logic [ffpa_pkg::OUT_CNT_W-1:0]     rsp_free_count
);
   import ffpa_pkg::*;

   logic [1:0]                mode_ff, mode_in;
   logic [LEN_W-1:0]          size_ff, size_in;
   logic [POOL_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          nalloc_ff, nalloc_in;
   logic [CNT_W-1:0]          nfree_ff, nfree_in;
   logic [CNT_W-1:0]          p_ff, p_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic [1:0]                k_ff, k_in;
   seg_type                   cur_ff, cur_in;
   seg_type                   prev_ff, prev_in;
   seg_type                   nxt_ff, nxt_in;
   logic                      nxt_ok_ff, nxt_ok_in;
   logic [1:0]                res_ff, res_in;
   logic [POOL_ADDR_BITS-1:0] blk_ff, blk_in;

   logic                      rd_en, wr_en;
   logic [IDX_W-1:0]          rd_addr, wr_addr;
   seg_type                   wr_data, rd_seg;
   logic [$bits(seg_type)-1:0] rd_raw;
   logic                      match;
   logic [LEN_W:0]            seg_end;
   logic [CNT_W-1:0]          p_inc;
   logic                      pf, nf;
   logic [1:0]                kmerge;
   logic [CNT_W-1:0]          j_plus_k;

   ffpa_ram #(
      .WIDTH ($bits(seg_type)),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_seg   = seg_type'(rd_raw);
   assign p_inc    = p_ff + CNT_W'(1);
   assign j_plus_k = j_ff + CNT_W'(k_ff);
   assign seg_end  = {2'b00, rd_seg.start} + {1'b0, rd_seg.len};

   // Match test of the entry just read, per mode
   always_comb begin
      case (mode_ff)
         MODE_ALLOC: match = rd_seg.free && (rd_seg.len >= size_ff);
         MODE_FREE:  match = !rd_seg.free && (rd_seg.start == addr_ff);
         MODE_CHECK: match = !rd_seg.free && (addr_ff >= rd_seg.start) &&
                             ({2'b00, addr_ff} < seg_end);
         default:    match = 1'b0;
      endcase
   end

   // Merge decision from the held neighbours
   assign pf     = (p_ff != '0) && prev_ff.free;
   assign nf     = nxt_ok_ff && nxt_ff.free;
   assign kmerge = {1'b0, pf} + {1'b0, nf};

   // Status back to the controller
   always_comb begin
      status.mode       = mode_ff;
      status.zero_size  = (size_ff == '0);
      status.match      = match;
      status.last       = (p_inc == n_ff);
      status.exact      = (cur_ff.len == size_ff);
      status.full       = (n_ff == CNT_W'(MAX_SEGMENTS));
      status.has_next   = (p_inc < n_ff);
      status.up_done    = (j_ff == p_inc);
      status.dn_done    = (j_ff >= n_ff);
      status.shift_down = (k_ff != '0);
   end

   // RAM port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = p_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = p_ff[IDX_W-1:0];
      wr_data = cur_ff;
      case (cmd)
         CMD_SCAN_RD: begin
            rd_en = 1'b1;
         end
         CMD_NEXT_RD: begin
            rd_en   = 1'b1;
            rd_addr = p_inc[IDX_W-1:0];
         end
         CMD_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = dn_phase ? j_plus_k[IDX_W-1:0] : j_ff[IDX_W-1:0] - IDX_W'(1);
         end
         CMD_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_seg;
         end
         CMD_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{start: '0, len: pool_size, free: 1'b1};
         end
         CMD_TAKE: begin
            wr_en   = 1'b1;
            wr_data = '{start: cur_ff.start, len: cur_ff.len, free: 1'b0};
         end
         CMD_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = p_inc[IDX_W-1:0];
            wr_data = '{start: cur_ff.start + size_ff[POOL_ADDR_BITS-1:0],
                        len: cur_ff.len - size_ff, free: 1'b1};
         end
         CMD_HEAD: begin
            wr_en   = 1'b1;
            wr_data = '{start: cur_ff.start, len: size_ff, free: 1'b0};
         end
         CMD_MERGE: begin
            wr_en = 1'b1;
            if (pf) begin
               wr_addr = p_ff[IDX_W-1:0] - IDX_W'(1);
               wr_data = '{start: prev_ff.start,
                           len: prev_ff.len + cur_ff.len + (nf ? nxt_ff.len : '0),
                           free: 1'b1};
            end else if (nf) begin
               wr_data = '{start: cur_ff.start, len: cur_ff.len + nxt_ff.len,
                           free: 1'b1};
            end else begin
               wr_data = '{start: cur_ff.start, len: cur_ff.len, free: 1'b1};
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Register updates per command
   always_comb begin
      mode_in   = mode_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      n_in      = n_ff;
      nalloc_in = nalloc_ff;
      nfree_in  = nfree_ff;
      p_in      = p_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      nxt_in    = nxt_ff;
      nxt_ok_in = nxt_ok_ff;
      res_in    = res_ff;
      blk_in    = blk_ff;
      case (cmd)
         CMD_LOAD: begin
            mode_in   = req_mode;
            size_in   = req_request_size;
            addr_in   = req_address;
            p_in      = '0;
            nxt_ok_in = 1'b0;
            res_in    = ST_OK;
            blk_in    = '0;
         end
         CMD_INIT: begin
            n_in      = CNT_W'(1);
            nalloc_in = '0;
            nfree_in  = CNT_W'(1);
         end
         CMD_FAIL: begin
            res_in = (mode_ff == MODE_ALLOC) ? ST_NO_FIT : ST_NOT_ALLOC;
         end
         CMD_FULL: begin
            res_in = ST_FULL;
         end
         CMD_SCAN_EV: begin
            cur_in = rd_seg;
            if (!match) begin
               prev_in = rd_seg;
               p_in    = p_inc;
            end
         end
         CMD_TAKE: begin
            nalloc_in = nalloc_ff + CNT_W'(1);
            nfree_in  = nfree_ff - CNT_W'(1);
            blk_in    = cur_ff.start;
         end
         CMD_UP_INIT: begin
            j_in = n_ff;
            k_in = '0;
         end
         CMD_UP_WR: begin
            j_in = dn_phase ? j_ff + CNT_W'(1) : j_ff - CNT_W'(1);
         end
         CMD_HEAD: begin
            n_in      = n_ff + CNT_W'(1);
            nalloc_in = nalloc_ff + CNT_W'(1);
            blk_in    = cur_ff.start;
         end
         CMD_NEXT_EV: begin
            nxt_in    = rd_seg;
            nxt_ok_in = 1'b1;
         end
         CMD_MERGE: begin
            k_in      = kmerge;
            n_in      = n_ff - CNT_W'(kmerge);
            nalloc_in = nalloc_ff - CNT_W'(1);
            nfree_in  = nfree_ff + CNT_W'(1) - CNT_W'(kmerge);
            if (pf) begin
               j_in = p_ff;
            end else if (nf) begin
               j_in = p_inc;
            end else begin
               j_in = n_ff;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= CNT_W'(1);
         nalloc_ff <= '0;
         nfree_ff  <= CNT_W'(1);
         p_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         nxt_ok_ff <= 1'b0;
         mode_ff   <= MODE_ALLOC;
      end else begin
         n_ff      <= n_in;
         nalloc_ff <= nalloc_in;
         nfree_ff  <= nfree_in;
         p_ff      <= p_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         nxt_ok_ff <= nxt_ok_in;
         mode_ff   <= mode_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      size_ff <= size_in;
      addr_ff <= addr_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      nxt_ff  <= nxt_in;
      res_ff  <= res_in;
      blk_ff  <= blk_in;
   end

   assign rsp_status          = res_ff;
   assign rsp_block_address   = blk_ff;
   assign rsp_allocated_count = OUT_CNT_W'(nalloc_ff);
   assign rsp_free_count      = OUT_CNT_W'(nfree_ff);

   // Counts always add up to the table occupancy
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      (nalloc_ff + nfree_ff) == n_ff)
      else $error("segment counts do not add up to table occupancy");

   // Occupancy stays within the table
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (n_ff != '0) && (n_ff <= CNT_W'(MAX_SEGMENTS)))
      else $error("segment table occupancy out of range");

   // A table write is never issued in the same cycle as a read
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("table read and write collide");

endmodule

// File: rtl/core/ffpa_ctrl.sv
// Controller state machine of the allocator: sequences scans, shifts and merges
// by issuing datapath commands. Depends on ffpa_pkg.
module ffpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ffpa_pkg::dp_status_type status,
   output ffpa_pkg::cmd_type       cmd,
   output logic                    dn_phase
);
   import ffpa_pkg::*;

   localparam logic [4:0] S_BOOT = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_DISP = 5'd2;
   localparam logic [4:0] S_SRD  = 5'd3;
   localparam logic [4:0] S_SEV  = 5'd4;
   localparam logic [4:0] S_AFIT = 5'd5;
   localparam logic [4:0] S_UCHK = 5'd6;
   localparam logic [4:0] S_UWR  = 5'd7;
   localparam logic [4:0] S_HEAD = 5'd8;
   localparam logic [4:0] S_NRD  = 5'd9;
   localparam logic [4:0] S_NEV  = 5'd10;
   localparam logic [4:0] S_MRG  = 5'd11;
   localparam logic [4:0] S_DCHK = 5'd12;
   localparam logic [4:0] S_DWR  = 5'd13;
   localparam logic [4:0] S_FAIL = 5'd14;
   localparam logic [4:0] S_RESP = 5'd15;

   logic [4:0] state_ff, state_in;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      dn_phase = 1'b0;
      case (state_ff)
         S_BOOT: begin
            cmd      = CMD_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (status.mode == MODE_REINIT) begin
               cmd      = CMD_INIT;
               state_in = S_RESP;
            end else if (status.mode == MODE_ALLOC && status.zero_size) begin
               cmd      = CMD_FAIL;
               state_in = S_RESP;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            cmd      = CMD_SCAN_RD;
            state_in = S_SEV;
         end
         S_SEV: begin
            cmd = CMD_SCAN_EV;
            if (status.match) begin
               case (status.mode)
                  MODE_ALLOC: state_in = S_AFIT;
                  MODE_FREE:  state_in = status.has_next ? S_NRD : S_MRG;
                  default:    state_in = S_RESP;
               endcase
            end else if (status.last) begin
               state_in = S_FAIL;
            end else begin
               state_in = S_SRD;
            end
         end
         S_AFIT: begin
            if (status.exact) begin
               cmd      = CMD_TAKE;
               state_in = S_RESP;
            end else if (status.full) begin
               cmd      = CMD_FULL;
               state_in = S_RESP;
            end else begin
               cmd      = CMD_UP_INIT;
               state_in = S_UCHK;
            end
         end
         // open a gap above the split entry, top entry first
         S_UCHK: begin
            if (status.up_done) begin
               cmd      = CMD_TAIL;
               state_in = S_HEAD;
            end else begin
               cmd      = CMD_UP_RD;
               state_in = S_UWR;
            end
         end
         S_UWR: begin
            cmd      = CMD_UP_WR;
            state_in = S_UCHK;
         end
         S_HEAD: begin
            cmd      = CMD_HEAD;
            state_in = S_RESP;
         end
         S_NRD: begin
            cmd      = CMD_NEXT_RD;
            state_in = S_NEV;
         end
         S_NEV: begin
            cmd      = CMD_NEXT_EV;
            state_in = S_MRG;
         end
         S_MRG: begin
            cmd      = CMD_MERGE;
            state_in = S_DCHK;
         end
         // close the gap left by merged entries, bottom entry first
         S_DCHK: begin
            dn_phase = 1'b1;
            if (status.dn_done || !status.shift_down) begin
               state_in = S_RESP;
            end else begin
               cmd      = CMD_DN_RD;
               state_in = S_DWR;
            end
         end
         S_DWR: begin
            dn_phase = 1'b1;
            cmd      = CMD_UP_WR;
            state_in = S_DCHK;
         end
         S_FAIL: begin
            cmd      = CMD_FAIL;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // A held result keeps the input side closed
   a_resp_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // An accepted item leads straight to dispatch
   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISP))
      else $error("accepted item not dispatched");

   // A stalled result stays offered
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

// File: rtl/core/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator: configuration register and the
// controller/datapath pair. Depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath.
//
// Use: present a request (mode, request_size, address) on the req_ channel;
// it is taken when req_valid is high and req_stall low. One result per
// request comes back on the rsp_ channel and is held until rsp_stall is low.
// One request is in flight at a time; req_stall stays high until its result
// has been taken.
// Scan: a request reads each segment table entry from RAM, then evaluates
// it, and stops at the first match. A split moves the entries above the
// split entry up; a free moves entries down after merging.
// Reset: pool_size returns to 65536 and the table to one free segment
// covering it, written in a boot state before the first request is taken.
// pool_size is written through the csr_ port at address 0; of the write data
// only the low 17 bits are kept, 0 reads as 1 and values above the address
// space are clamped. It takes effect at the next reinitialise request.
module first_fit_pool_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [ffpa_pkg::LEN_W-1:0]          req_request_size,
   input  logic [ffpa_pkg::POOL_ADDR_BITS-1:0] req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [ffpa_pkg::POOL_ADDR_BITS-1:0] rsp_block_address,
   output logic [ffpa_pkg::OUT_CNT_W-1:0]      rsp_allocated_count,
   output logic [ffpa_pkg::OUT_CNT_W-1:0]      rsp_free_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ffpa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ffpa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ffpa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ffpa_pkg::*;

   logic [LEN_W-1:0] pool_ff, pool_in;
   logic [LEN_W-1:0] wval;
   logic             csr_wr;
   logic             csr_hit;
   cmd_type          cmd;
   logic             dn_phase;
   dp_status_type    status;

   // Clamp and hold the pool size register
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit = (csr_paddr[CSR_ADDR_W-1:2] == CSR_POOL_SIZE[CSR_ADDR_W-1:2]);
   assign wval    = csr_pwdata[LEN_W-1:0];

   always_comb begin
      pool_in = pool_ff;
      if (csr_wr && csr_hit) begin
         if (wval == '0) begin
            pool_in = LEN_W'(1);
         end else if (wval > POOL_MAX) begin
            pool_in = POOL_MAX;
         end else begin
            pool_in = wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= POOL_MAX;
      end else begin
         pool_ff <= pool_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(pool_ff) : '0;

   ffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .dn_phase  (dn_phase)
   );

   ffpa_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dn_phase            (dn_phase),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_address         (req_address),
      .pool_size           (pool_ff),
      .status              (status),
      .rsp_status          (rsp_status),
      .rsp_block_address   (rsp_block_address),
      .rsp_allocated_count (rsp_allocated_count),
      .rsp_free_count      (rsp_free_count)
   );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the first-fit pool allocator: directed table, then random
// allocate/free/check/reinitialise traffic over several pool sizes, checked by a predictor.
// Depends on ffpa_pkg and first_fit_pool_allocator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 225;

   typedef struct packed {
      logic [1:0]                status;
      logic [POOL_ADDR_BITS-1:0] block_address;
      logic [OUT_CNT_W-1:0]      allocated_count;
      logic [OUT_CNT_W-1:0]      free_count;
   } outcome_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic [LEN_W-1:0]          size;
      logic [POOL_ADDR_BITS-1:0] addr;
      logic                      typed;
      outcome_type               want;
   } stim_row_type;

   logic                      clock, reset;
   logic                      req_valid, req_stall;
   logic [1:0]                req_mode;
   logic [LEN_W-1:0]          req_request_size;
   logic [POOL_ADDR_BITS-1:0] req_address;
   logic                      rsp_valid, rsp_stall;
   logic [1:0]                rsp_status;
   logic [POOL_ADDR_BITS-1:0] rsp_block_address;
   logic [OUT_CNT_W-1:0]      rsp_allocated_count, rsp_free_count;
   logic                      csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata, csr_prdata;

   // predictor state: segment table and pool size
   logic [LEN_W-1:0] seg_start [MAX_SEGMENTS];
   logic [LEN_W-1:0] seg_len   [MAX_SEGMENTS];
   logic             seg_free  [MAX_SEGMENTS];
   int               seg_used;
   logic [LEN_W-1:0] pool_bytes;

   outcome_type pending_results[$];
   int       errors = 0;
   int       cycles = 0;
   int       hold_cycles = 0;
   bit       quiet = 0;

   first_fit_pool_allocator i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void table_init();
      seg_start[0] = '0;
      seg_len[0]   = pool_bytes;
      seg_free[0]  = 1'b1;
      seg_used     = 1;
   endfunction

   function automatic void drop_segment(int k);
      for (int j = k; j + 1 < seg_used; j++) begin
         seg_start[j] = seg_start[j+1];
         seg_len[j]   = seg_len[j+1];
         seg_free[j]  = seg_free[j+1];
      end
      seg_used--;
   endfunction

   // Advance the table by one request and return the outcome it must give
   function automatic outcome_type predict_outcome(logic [1:0] mode, logic [LEN_W-1:0] size,
                                                   logic [POOL_ADDR_BITS-1:0] addr);
      outcome_type res;
      bit       found;
      int       k;
      res = '0;
      found = 0;
      case (mode)
         MODE_ALLOC: begin
            res.status = ST_NO_FIT;
            if (size != 0) begin
               for (int i = 0; i < seg_used && !found; i++) begin
                  if (seg_free[i] && seg_len[i] >= size) begin
                     found = 1;
                     if (seg_len[i] > size && seg_used >= MAX_SEGMENTS) begin
                        res.status = ST_FULL;
                     end else begin
                        if (seg_len[i] > size) begin
                           for (int j = seg_used; j > i + 1; j--) begin
                              seg_start[j] = seg_start[j-1];
                              seg_len[j]   = seg_len[j-1];
                              seg_free[j]  = seg_free[j-1];
                           end
                           seg_start[i+1] = seg_start[i] + size;
                           seg_len[i+1]   = seg_len[i] - size;
                           seg_free[i+1]  = 1'b1;
                           seg_len[i]     = size;
                           seg_used++;
                        end
                        seg_free[i]       = 1'b0;
                        res.status        = ST_OK;
                        res.block_address = seg_start[i][POOL_ADDR_BITS-1:0];
                     end
                  end
               end
            end
         end
         MODE_FREE: begin
            res.status = ST_NOT_ALLOC;
            k = -1;
            for (int i = 0; i < seg_used && k < 0; i++)
               if (seg_start[i] == addr && !seg_free[i]) k = i;
            if (k >= 0) begin
               res.status  = ST_OK;
               seg_free[k] = 1'b1;
               if (k > 0 && seg_free[k-1]) begin
                  seg_len[k-1] += seg_len[k];
                  drop_segment(k);
                  k--;
               end
               if (k + 1 < seg_used && seg_free[k+1]) begin
                  seg_len[k] += seg_len[k+1];
                  drop_segment(k + 1);
               end
            end
         end
         MODE_CHECK: begin
            res.status = ST_NOT_ALLOC;
            for (int i = 0; i < seg_used; i++)
               if (!seg_free[i] && addr >= seg_start[i] && addr < seg_start[i] + seg_len[i])
                  res.status = ST_OK;
         end
         default: table_init();
      endcase
      for (int i = 0; i < seg_used; i++)
         if (seg_free[i]) res.free_count++;
         else res.allocated_count++;
      return res;
   endfunction

   // Offer one request, hold it until the transfer, then record its outcome
   task automatic send_request(logic [1:0] mode, logic [LEN_W-1:0] size,
                               logic [POOL_ADDR_BITS-1:0] addr, logic typed, outcome_type want);
      outcome_type predicted;
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_size <= size;
      req_address      <= addr;
      do @(posedge clock); while (req_stall);
      predicted = predict_outcome(mode, size, addr);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
   endtask

   // Write the pool size while the block is idle, then reinitialise to apply it
   task automatic write_pool_size(logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (300) @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CSR_POOL_SIZE;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      value = value & 32'h1FFFF;
      if (value == 0) value = 1;
      if (value > CSR_DATA_W'(POOL_MAX)) value = CSR_DATA_W'(POOL_MAX);
      pool_bytes = value[LEN_W-1:0];
      send_request(MODE_REINIT, '0, '0, 1'b0, '0);
   endtask

   task automatic send_random();
      logic [1:0]                mode;
      logic [LEN_W-1:0]          size;
      logic [POOL_ADDR_BITS-1:0] addr;
      int                        r, k;
      r    = $urandom_range(99);
      size = LEN_W'($urandom);
      addr = POOL_ADDR_BITS'($urandom);
      k    = $urandom_range(seg_used - 1);
      if (r < 52) begin
         mode = MODE_ALLOC;
         r = $urandom_range(99);
         if (r < 70) size = LEN_W'($urandom_range(16, 1));
         else if (r < 90) size = LEN_W'($urandom_range(pool_bytes / 4 + 1, 1));
         else if (r < 95) size = '0;
      end else if (r < 78) begin
         mode = MODE_FREE;
         if ($urandom_range(3) != 0) addr = seg_start[k][POOL_ADDR_BITS-1:0];
      end else if (r < 98) begin
         mode = MODE_CHECK;
         if ($urandom_range(4) < 3)
            addr = POOL_ADDR_BITS'(seg_start[k] + LEN_W'($urandom_range(seg_len[k] - 1)));
      end else begin
         mode = MODE_REINIT;
      end
      send_request(mode, size, addr, 1'b0, '0);
   endtask

   // Directed requests; typed outcomes are those readable straight off the behaviour
   stim_row_type directed [16] = '{
      '{MODE_ALLOC,  17'd0,       16'd0,      1'b1, '{ST_NO_FIT,    16'd0, 7'd0, 7'd1}},
      '{MODE_ALLOC,  17'd65537,   16'hFFFF,   1'b1, '{ST_NO_FIT,    16'd0, 7'd0, 7'd1}},
      '{MODE_FREE,   17'd0,       16'd0,      1'b1, '{ST_NOT_ALLOC, 16'd0, 7'd0, 7'd1}},
      '{MODE_CHECK,  17'd0,       16'd0,      1'b1, '{ST_NOT_ALLOC, 16'd0, 7'd0, 7'd1}},
      '{MODE_ALLOC,  17'd65536,   16'd0,      1'b1, '{ST_OK,        16'd0, 7'd1, 7'd0}},
      '{MODE_CHECK,  17'd0,       16'hFFFF,   1'b1, '{ST_OK,        16'd0, 7'd1, 7'd0}},
      '{MODE_ALLOC,  17'd1,       16'd0,      1'b1, '{ST_NO_FIT,    16'd0, 7'd1, 7'd0}},
      '{MODE_FREE,   17'd0,       16'd0,      1'b1, '{ST_OK,        16'd0, 7'd0, 7'd1}},
      '{MODE_ALLOC,  17'd1,       16'd0,      1'b1, '{ST_OK,        16'd0, 7'd1, 7'd1}},
      '{MODE_ALLOC,  17'h1FFFF,   16'd0,      1'b1, '{ST_NO_FIT,    16'd0, 7'd1, 7'd1}},
      '{MODE_ALLOC,  17'd2,       16'd0,      1'b1, '{ST_OK,        16'd1, 7'd2, 7'd1}},
      '{MODE_ALLOC,  17'd100,     16'd0,      1'b0, '0},
      '{MODE_CHECK,  17'd0,       16'd50,     1'b0, '0},
      '{MODE_FREE,   17'd0,       16'd0,      1'b0, '0},
      '{MODE_FREE,   17'd0,       16'd1,      1'b0, '0},
      '{MODE_REINIT, 17'h1FFFF,   16'hFFFF,   1'b1, '{ST_OK,        16'd0, 7'd0, 7'd1}}
   };

   // Stimulus
   initial begin
      logic [CSR_DATA_W-1:0] sizes [5];
      sizes = '{32'd0, 32'd200, 32'h1FFFF, 32'd1, 32'd65536};
      reset = 1'b1;
      req_valid = 1'b0; req_mode = '0; req_request_size = '0; req_address = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      pool_bytes = POOL_MAX;
      table_init();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[n])
         send_request(directed[n].mode, directed[n].size, directed[n].addr,
                      directed[n].typed, directed[n].want);
      // fill the table with a long receiver hold-off in the middle
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == 40) hold_cycles = 400;
         send_random();
      end
      for (int p = 0; p < 5; p++) begin
         if (p == 4) quiet = 1;
         write_pool_size(p == 2 ? 32'd0 + $urandom_range(65536, 2) : sizes[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Drive the result stall: long hold-off when asked, else random bursts
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(4) == 0) begin
            burst = $urandom_range(4, 0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each result transfer with the oldest outcome waiting
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none waiting: status %0h", $time, rsp_status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0h actual %0h", $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_block_address !== want.block_address) begin
               $display("%0t: block_address expected %0h actual %0h", $time,
                        want.block_address, rsp_block_address);
               errors++;
            end
            if (rsp_allocated_count !== want.allocated_count) begin
               $display("%0t: allocated_count expected %0d actual %0d", $time,
                        want.allocated_count, rsp_allocated_count);
               errors++;
            end
            if (rsp_free_count !== want.free_count) begin
               $display("%0t: free_count expected %0d actual %0d", $time,
                        want.free_count, rsp_free_count);
               errors++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results waiting", $time, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

// File: files.f
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_ram.sv
rtl/core/ffpa_datapath.sv
rtl/core/ffpa_ctrl.sv
rtl/core/first_fit_pool_allocator.sv
dv/testbench.sv
